### rtl/assert_macros.svh
// Assertion helper macros for the key/value extractor RTL.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// When pre holds at one edge, post must hold at the following edge.
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

### rtl/ikve_pkg.sv
// Shared types and constants for the settings-text key/value extractor.
// Used by the channel interfaces, the parser and the top level; no dependencies.
`default_nettype none

package ikve_pkg;

   // Key storage: 31 characters, character 0 in the lowest byte.
   localparam int KEY_CHARS = 31;
   typedef logic [KEY_CHARS-1:0][7:0] key_type;

   // Configuration register indexes.
   typedef logic [2:0] csr_index_type;
   localparam csr_index_type CSR_KEY_0_7   = 3'd0;
   localparam csr_index_type CSR_KEY_8_15  = 3'd1;
   localparam csr_index_type CSR_KEY_16_23 = 3'd2;
   localparam csr_index_type CSR_KEY_24_30 = 3'd3;
   localparam csr_index_type CSR_VALUE_CAP = 3'd4;

   localparam logic [7:0] CAP_RESET = 8'd255;

   // Result kinds.
   localparam logic KIND_VALUE  = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Characters the parser recognizes.
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_SEMI  = 8'h3B;
   localparam logic [7:0] CH_EQ    = 8'h3D;

   // Results of one parsed byte: an optional value byte, then an optional status.
   typedef struct packed {
      logic       value_v;
      logic [7:0] value_b;
      logic       status_v;
      logic       status_found;
   } result_type;

   // One queued result word.
   typedef struct packed {
      logic       kind;
      logic [7:0] value_b;
      logic       found;
   } word_type;

endpackage

`default_nettype wire

### rtl/ikve_if.sv
// Valid/ready channel interfaces of the key/value extractor: text input,
// results and register writes. Depends on ikve_pkg.
`default_nettype none

interface ikve_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, text_byte, end_of_text, input ready);
   modport sink   (input valid, text_byte, end_of_text, output ready);
endinterface

interface ikve_rsp_if;
   logic       valid;
   logic       ready;
   logic       result_kind;
   logic [7:0] value_byte;
   logic       key_found;
   logic       last_of_run;

   modport source (output valid, result_kind, value_byte, key_found, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, value_byte, key_found, last_of_run,
                   output ready);
endinterface

interface ikve_csr_if
   import ikve_pkg::*;
   ;
   logic          valid;
   logic          ready;
   csr_index_type index;
   logic [63:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/ikve_parser.sv
// Per-byte parse state machine: tracks line phase, name match and value copy.
// Depends on ikve_pkg.
`default_nettype none

module ikve_parser
   import ikve_pkg::*;
#(
   parameter int NAME_MAX_CHARS = 31
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] text_byte,
   input  wire logic       end_of_text,
   input  wire key_type    key,
   input  wire logic [7:0] capacity,
   output result_type      result
);

   localparam int NLW = $clog2(NAME_MAX_CHARS + 1);

   typedef enum logic [5:0] {
      PH_LINE_START = 6'b000001,
      PH_NAME       = 6'b000010,
      PH_BETWEEN    = 6'b000100,
      PH_COPY       = 6'b001000,
      PH_SKIP       = 6'b010000,
      PH_DONE       = 6'b100000
   } phase_type;

   phase_type        phase_ff, phase_in;
   logic [NLW-1:0]   nl_ff, nl_in;
   logic             match_ff, match_in;
   logic             quote_ff, quote_in;
   logic [7:0]       room_ff, room_in;
   logic             rep_ff, rep_in;

   logic             busy;
   logic [NLW-1:0]   nl_look;
   logic             match_look;
   logic [7:0]       key_char;
   logic             name_hit;
   logic             is_space, is_alnum, is_eol, is_sep, is_quote;

   // Key character at a name position; positions past the key read as zero.
   function automatic logic [7:0] key_at(key_type k, logic [6:0] idx);
      logic [7:0] c;
      c = 8'd0;
      for (int i = 0; i < KEY_CHARS; i++) begin
         if (idx == 7'(i)) c = k[i];
      end
      return c;
   endfunction

   // Character classes of the incoming byte.
   assign is_space = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                     (text_byte == CH_LF) || (text_byte == CH_VT) ||
                     (text_byte == CH_FF) || (text_byte == CH_CR);
   assign is_alnum = (text_byte >= 8'h30 && text_byte <= 8'h39) ||
                     (text_byte >= 8'h41 && text_byte <= 8'h5A) ||
                     (text_byte >= 8'h61 && text_byte <= 8'h7A);
   assign is_eol   = (text_byte == CH_LF) || (text_byte == CH_CR);
   assign is_sep   = (text_byte == CH_SPACE) || (text_byte == CH_TAB) ||
                     (text_byte == CH_EQ) || (text_byte == CH_COLON);
   assign is_quote = (text_byte == CH_QUOTE);

   // A byte at line start begins a fresh name, so the lookup uses position zero.
   assign nl_look    = (phase_ff == PH_LINE_START) ? '0 : nl_ff;
   assign match_look = (phase_ff == PH_LINE_START) ? 1'b1 : match_ff;
   assign key_char   = key_at(key, 7'(nl_look));
   assign name_hit   = match_look &&
                       ((nl_look >= NLW'(NAME_MAX_CHARS)) || (key_char == 8'd0));

   // Phases fall through in order within one byte, so each block may hand on.
   always_comb begin
      phase_in = phase_ff;
      nl_in    = nl_ff;
      match_in = match_ff;
      quote_in = quote_ff;
      room_in  = room_ff;
      rep_in   = rep_ff;
      busy     = 1'b1;
      result   = '0;
      result.value_b = text_byte;

      if (phase_ff == PH_LINE_START) begin
         if (is_space) begin
            busy = 1'b0;
         end else if (text_byte == CH_SEMI) begin
            quote_in = 1'b0;
            phase_in = PH_SKIP;
            busy     = 1'b0;
         end else begin
            nl_in    = '0;
            match_in = 1'b1;
            phase_in = PH_NAME;
         end
      end

      if (busy && phase_in == PH_NAME) begin
         if (is_alnum) begin
            if (nl_in < NLW'(NAME_MAX_CHARS)) begin
               if (text_byte != key_char) match_in = 1'b0;
               nl_in = nl_in + NLW'(1);
            end
            busy = 1'b0;
         end else begin
            phase_in = PH_BETWEEN;
         end
      end

      if (busy && phase_in == PH_BETWEEN) begin
         if (is_eol) begin
            if (name_hit) begin
               result.value_v = 1'b1;
               result.value_b = CH_ONE;
               phase_in       = PH_DONE;
            end else begin
               phase_in = PH_LINE_START;
            end
            busy = 1'b0;
         end else if (is_sep) begin
            busy = 1'b0;
         end else begin
            if (name_hit) begin
               phase_in = PH_COPY;
               room_in  = capacity;
            end else begin
               phase_in = PH_SKIP;
            end
            quote_in = is_quote;
            if (is_quote) busy = 1'b0;
         end
      end

      if (busy && phase_in == PH_COPY) begin
         if (quote_in ? is_quote : is_eol) begin
            phase_in = PH_DONE;
         end else if (room_in != 8'd0) begin
            result.value_v = 1'b1;
            room_in        = room_in - 8'd1;
         end
         busy = 1'b0;
      end

      // A line end in a skipped bare value returns to line start, where it is blank.
      if (busy && phase_in == PH_SKIP) begin
         if (quote_in) begin
            if (is_quote) quote_in = 1'b0;
         end else if (is_eol) begin
            phase_in = PH_LINE_START;
         end
      end

      // Status when the search ends, or at the end of the text if still open.
      if (phase_in == PH_DONE && !rep_in) begin
         result.status_v     = 1'b1;
         result.status_found = 1'b1;
         rep_in              = 1'b1;
      end
      if (end_of_text) begin
         if (!rep_in) begin
            result.status_v     = 1'b1;
            result.status_found = (phase_in == PH_COPY);
         end
         phase_in = PH_LINE_START;
         nl_in    = '0;
         match_in = 1'b1;
         quote_in = 1'b0;
         room_in  = capacity;
         rep_in   = 1'b0;
      end
   end

   // Parse state advances once per processed byte.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_LINE_START;
         nl_ff    <= '0;
         match_ff <= 1'b1;
         quote_ff <= 1'b0;
         room_ff  <= capacity;
         rep_ff   <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in;
         nl_ff    <= nl_in;
         match_ff <= match_in;
         quote_ff <= quote_in;
         room_ff  <= room_in;
         rep_ff   <= rep_in;
      end
   end

endmodule

`default_nettype wire

### rtl/ini_key_value_extractor.sv
// Top level of the settings-text key/value extractor: input register, register
// file, parser and result queue. Depends on ikve_pkg, ikve_if, ikve_parser.
//
// Usage:
//   req_if carries one text byte per word with an end-of-text flag. rsp_if
//   returns value bytes (result_kind 0) and one status word per text
//   (result_kind 1, last_of_run 1, key_found). csr_if writes the key
//   registers (indexes 0 to 3) and the value capacity (index 4); it is always
//   ready and a write takes effect at the next edge.
//   Order: an accepted byte waits in the input register, is parsed into a
//   four-word result queue, and the queue head is offered on rsp_if.
//   Throughput: one byte per cycle while two queue slots are free. A byte
//   yields at most two words: the value byte '1' plus the status for a bare
//   matching name, or a last copied value byte plus the status when the text
//   ends. The result port drains one word per cycle while rsp_if is ready,
//   and the queue absorbs the extra word.
//   Stall: while rsp_if is not ready the queue fills; a byte is parsed only
//   when two queue slots are free, otherwise it waits in the input register
//   and req_if drops ready.
//   Reset: clears the key, sets the capacity to 255, empties the queue and
//   returns the parser to line start. After each end-of-text byte the parser
//   re-arms for a new text; key and capacity are kept.
`default_nettype none
`include "assert_macros.svh"

module ini_key_value_extractor
   import ikve_pkg::*;
#(
   parameter int NAME_MAX_CHARS = 31
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ikve_req_if.sink   req_if,
   ikve_rsp_if.source rsp_if,
   ikve_csr_if.sink   csr_if
);

   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = $clog2(FIFO_DEPTH);
   localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

   // Input register.
   logic        stage_v_ff, stage_v_in;
   logic [7:0]  stage_byte_ff;
   logic        stage_eot_ff;
   logic        fire;
   logic        take;

   // Configuration registers.
   key_type     key_ff;
   logic [7:0]  cap_ff;

   // Result queue.
   word_type             fifo_ff [FIFO_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 push0, push1, pop;
   logic [1:0]           npush;
   word_type             word0, word1;
   result_type           res;

   // A buffered byte is parsed when two queue slots are free.
   assign fire       = stage_v_ff && (cnt_ff <= CNT_W'(FIFO_DEPTH - 2));
   assign req_if.ready = !stage_v_ff || fire;
   assign take       = req_if.valid && req_if.ready;
   assign stage_v_in = take || (stage_v_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_v_ff <= 1'b0;
      end else begin
         stage_v_ff <= stage_v_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         stage_byte_ff <= req_if.text_byte;
         stage_eot_ff  <= req_if.end_of_text;
      end
   end

   // Register writes; unknown indexes are ignored.
   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
         cap_ff <= CAP_RESET;
      end else if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_KEY_0_7:   key_ff[7:0]   <= csr_if.data;
            CSR_KEY_8_15:  key_ff[15:8]  <= csr_if.data;
            CSR_KEY_16_23: key_ff[23:16] <= csr_if.data;
            CSR_KEY_24_30: key_ff[30:24] <= csr_if.data[55:0];
            CSR_VALUE_CAP: cap_ff        <= csr_if.data[7:0];
            default: ;
         endcase
      end
   end

   ikve_parser #(
      .NAME_MAX_CHARS (NAME_MAX_CHARS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (fire),
      .text_byte   (stage_byte_ff),
      .end_of_text (stage_eot_ff),
      .key         (key_ff),
      .capacity    (cap_ff),
      .result      (res)
   );

   // Order the parser's results: a value byte goes ahead of a status.
   assign push0 = fire && (res.value_v || res.status_v);
   assign push1 = fire && res.value_v && res.status_v;
   assign npush = {1'b0, push0} + {1'b0, push1};

   assign word0 = res.value_v
                ? word_type'{kind: KIND_VALUE, value_b: res.value_b, found: 1'b0}
                : word_type'{kind: KIND_STATUS, value_b: 8'd0, found: res.status_found};
   assign word1 = word_type'{kind: KIND_STATUS, value_b: 8'd0, found: res.status_found};

   assign pop       = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_in = wr_ptr_ff + PTR_W'(npush);
   assign rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
   assign cnt_in    = cnt_ff + CNT_W'(npush) - CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push0) fifo_ff[wr_ptr_ff] <= word0;
      if (push1) fifo_ff[wr_ptr_ff + PTR_W'(1)] <= word1;
   end

   // Result port reads the queue head.
   assign rsp_if.valid       = (cnt_ff != '0);
   assign rsp_if.result_kind = fifo_ff[rd_ptr_ff].kind;
   assign rsp_if.value_byte  = fifo_ff[rd_ptr_ff].value_b;
   assign rsp_if.key_found   = fifo_ff[rd_ptr_ff].found;
   assign rsp_if.last_of_run = fifo_ff[rd_ptr_ff].kind;

   // The queue never overflows.
   `ASSERT_ALWAYS(a_queue_bound, clock, reset, cnt_ff <= CNT_W'(FIFO_DEPTH), "queue overflow")
   // A second word is only written together with a first one.
   `ASSERT_ALWAYS(a_queue_count, clock, reset, !(push1 && !push0), "second push without first")
   // A byte that cannot be parsed stays in the input register.
   `ASSERT_ALWAYS(a_stage_hold, clock, reset, !(stage_v_ff && !fire && req_if.ready), "stage lost")

endmodule

`default_nettype wire

### dv/tb_ini_key_value_extractor.sv
`timescale 1ns / 1ps
// Self-checking testbench for ini_key_value_extractor: settings texts are streamed
// in byte by byte and every result word is checked against a scoreboard that tracks
// the parser. Depends on ikve_pkg, ikve_if and the RTL of the block.

module tb_ini_key_value_extractor;
   import ikve_pkg::*;

   localparam int NAME_MAX = 31;
   localparam int CYCLE_LIMIT = 500000;
   localparam int TEXT_BYTES = 1200;

   typedef logic [7:0] octet_type;

   // Parser phases tracked by the scoreboard.
   typedef enum logic [5:0] {
      LINE_START = 6'b000001,
      IN_NAME    = 6'b000010,
      AFTER_NAME = 6'b000100,
      COPYING    = 6'b001000,
      SKIPPING   = 6'b010000,
      FOUND      = 6'b100000
   } scan_phase_type;

   // One result word as it leaves the block.
   typedef struct packed {
      logic       kind;
      logic [7:0] value_b;
      logic       found;
      logic       last;
   } kv_word_type;

   // Tracks the key search and holds the result words still owed by the block.
   class kv_scoreboard;
      key_type        key;
      logic [7:0]     capacity;
      scan_phase_type phase;
      int             name_len;
      bit             name_ok;
      bit             in_quotes;
      int             room;
      bit             reported;
      kv_word_type    awaited_words[$];
      int             errors;
      int             checked;

      function new();
         key = '0;
         capacity = CAP_RESET;
         errors = 0;
         checked = 0;
         rearm();
      endfunction

      function void rearm();
         phase = LINE_START;
         name_len = 0;
         name_ok = 1'b1;
         in_quotes = 1'b0;
         room = capacity;
         reported = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [63:0] d);
         case (idx)
            CSR_KEY_0_7:   for (int j = 0; j < 8; j++) key[j] = d[8*j +: 8];
            CSR_KEY_8_15:  for (int j = 0; j < 8; j++) key[8 + j] = d[8*j +: 8];
            CSR_KEY_16_23: for (int j = 0; j < 8; j++) key[16 + j] = d[8*j +: 8];
            CSR_KEY_24_30: for (int j = 0; j < 7; j++) key[24 + j] = d[8*j +: 8];
            CSR_VALUE_CAP: capacity = d[7:0];
            default: ;
         endcase
      endfunction

      function int words_outstanding();
         return awaited_words.size();
      endfunction

      function bit is_blank(octet_type b);
         return b == CH_SPACE || b == CH_TAB || b == CH_LF || b == CH_VT ||
                b == CH_FF || b == CH_CR;
      endfunction

      function bit is_alnum(octet_type b);
         return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") ||
                (b >= "a" && b <= "z");
      endfunction

      function bit is_line_end(octet_type b);
         return b == CH_LF || b == CH_CR;
      endfunction

      function octet_type key_char(int i);
         if (i >= KEY_CHARS) return 8'h00;
         return key[i];
      endfunction

      // The name matches if all kept characters matched and the key ends there.
      function bit name_hit();
         if (!name_ok) return 1'b0;
         if (name_len >= NAME_MAX) return 1'b1;
         return key_char(name_len) == 8'h00;
      endfunction

      function void add_value(octet_type b);
         awaited_words.push_back('{KIND_VALUE, b, 1'b0, 1'b0});
      endfunction

      function void add_status(logic f);
         awaited_words.push_back('{KIND_STATUS, 8'h00, f, 1'b1});
      endfunction

      // Advances the search by one text byte and queues the words it causes.
      function void note_text_byte(octet_type b, logic eot);
         bit again;
         do begin
            again = 1'b0;
            case (phase)
               LINE_START: begin
                  if (!is_blank(b)) begin
                     if (b == CH_SEMI) begin
                        in_quotes = 1'b0;
                        phase = SKIPPING;
                     end else begin
                        name_len = 0;
                        name_ok = 1'b1;
                        phase = IN_NAME;
                        again = 1'b1;
                     end
                  end
               end
               IN_NAME: begin
                  if (is_alnum(b)) begin
                     if (name_len < NAME_MAX) begin
                        if (b != key_char(name_len)) name_ok = 1'b0;
                        name_len++;
                     end
                  end else begin
                     phase = AFTER_NAME;
                     again = 1'b1;
                  end
               end
               AFTER_NAME: begin
                  if (is_line_end(b)) begin
                     // A bare matching name reports the value '1'.
                     if (name_hit()) begin
                        add_value(CH_ONE);
                        phase = FOUND;
                     end else begin
                        phase = LINE_START;
                     end
                  end else if (!(b == CH_SPACE || b == CH_TAB || b == CH_EQ ||
                                 b == CH_COLON)) begin
                     if (name_hit()) begin
                        phase = COPYING;
                        room = capacity;
                     end else begin
                        phase = SKIPPING;
                     end
                     in_quotes = (b == CH_QUOTE);
                     again = !in_quotes;
                  end
               end
               COPYING: begin
                  if (in_quotes ? (b == CH_QUOTE) : is_line_end(b)) begin
                     phase = FOUND;
                  end else if (room > 0) begin
                     add_value(b);
                     room--;
                  end
               end
               SKIPPING: begin
                  if (in_quotes) begin
                     if (b == CH_QUOTE) in_quotes = 1'b0;
                  end else if (is_line_end(b)) begin
                     phase = LINE_START;
                     again = 1'b1;
                  end
               end
               default: ;
            endcase
         end while (again);

         if (phase == FOUND && !reported) begin
            add_status(1'b1);
            reported = 1'b1;
         end

         // The end of the text closes the search with a status unless one was already reported.
         if (eot) begin
            if (!reported) add_status(phase == COPYING);
            rearm();
         end
      endfunction

      // Compares one accepted result word with the oldest one owed.
      function void check_word(logic kind, octet_type vb, logic found, logic last);
         kv_word_type got;
         kv_word_type want;
         got = '{kind, vb, found, last};
         checked++;
         if (awaited_words.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result word: kind %0d byte %02h found %0d last %0d",
                        kind, vb, found, last);
            return;
         end
         want = awaited_words.pop_front();
         if (got !== want) begin
            errors++;
            if (errors <= 10)
               $display({"word %0d: expected kind %0d byte %02h found %0d last %0d,",
                         " got kind %0d byte %02h found %0d last %0d"},
                        checked, want.kind, want.value_b, want.found, want.last,
                        kind, vb, found, last);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   ikve_req_if req_bus ();
   ikve_rsp_if rsp_bus ();
   ikve_csr_if csr_bus ();

   ini_key_value_extractor #(
      .NAME_MAX_CHARS(NAME_MAX)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_if(req_bus),
      .rsp_if(rsp_bus),
      .csr_if(csr_bus)
   );

   kv_scoreboard sb;
   octet_type    text_buf[$];
   octet_type    key_str[$];
   key_type      key_bytes;
   bit           no_idle = 1'b0;
   int           cycles = 0;
   int           bytes_sent = 0;
   int           texts_sent = 0;
   int           csr_writes = 0;

   // Free-running clock.
   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Cycles a side waits before its next word.
   function int draw_wait();
      return no_idle ? 0 : $urandom_range(0, 9);
   endfunction

   function octet_type rand_alnum();
      int r;
      r = $urandom_range(0, 61);
      if (r < 10) return 8'("0" + r);
      if (r < 36) return 8'("A" + r - 10);
      return 8'("a" + r - 36);
   endfunction

   // Mostly printable, now and then a byte above 127.
   function octet_type rand_text_char();
      if ($urandom_range(0, 9) == 0) return 8'($urandom_range(128, 255));
      return 8'($urandom_range(32, 126));
   endfunction

   function void push_str(string s);
      for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
   endfunction

   function void push_line_end();
      case ($urandom_range(0, 2))
         0: text_buf.push_back(CH_LF);
         1: text_buf.push_back(CH_CR);
         default: begin
            text_buf.push_back(CH_CR);
            text_buf.push_back(CH_LF);
         end
      endcase
   endfunction

   // Name of a settings line: the key, near misses of it, or something else.
   function void push_name();
      int choice;
      int n;
      choice = $urandom_range(0, 9);
      case (choice)
         0, 1, 2, 3, 9: foreach (key_str[i]) text_buf.push_back(key_str[i]);
         4: for (int i = 0; i + 1 < key_str.size(); i++) text_buf.push_back(key_str[i]);
         5: begin
            foreach (key_str[i]) text_buf.push_back(key_str[i]);
            n = $urandom_range(1, 3);
            repeat (n) text_buf.push_back(rand_alnum());
         end
         6: begin
            n = $urandom_range(1, 8);
            repeat (n) text_buf.push_back(rand_alnum());
         end
         7: begin
            // Overlong name starting with the key.
            foreach (key_str[i]) text_buf.push_back(key_str[i]);
            n = $urandom_range(32, 40) - key_str.size();
            repeat (n) text_buf.push_back(rand_alnum());
         end
         default: ;
      endcase
   endfunction

   // One line of settings text appended to the buffer.
   function void push_line();
      int kind;
      int n;
      octet_type c;
      n = $urandom_range(0, 2);
      repeat (n) begin
         case ($urandom_range(0, 5))
            0: text_buf.push_back(CH_TAB);
            1: text_buf.push_back(CH_LF);
            2: text_buf.push_back(8'($urandom_range(CH_VT, CH_CR)));
            default: text_buf.push_back(CH_SPACE);
         endcase
      end
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         text_buf.push_back(CH_SEMI);
         n = $urandom_range(0, 8);
         repeat (n) begin
            c = rand_text_char();
            text_buf.push_back(c);
         end
         push_line_end();
      end else if (kind == 1) begin
         n = $urandom_range(1, 6);
         repeat (n) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
         push_name();
         n = $urandom_range(0, 3);
         repeat (n) begin
            case ($urandom_range(0, 3))
               0: text_buf.push_back(CH_SPACE);
               1: text_buf.push_back(CH_TAB);
               2: text_buf.push_back(CH_EQ);
               default: text_buf.push_back(CH_COLON);
            endcase
         end
         case ($urandom_range(0, 5))
            0: ;
            1, 2, 3: begin
               // Bare value, sometimes longer than small capacities.
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 40)
                                               : $urandom_range(1, 12);
               repeat (n) text_buf.push_back(rand_text_char());
            end
            default: begin
               text_buf.push_back(CH_QUOTE);
               n = $urandom_range(0, 12);
               repeat (n) begin
                  c = rand_text_char();
                  if (c == CH_QUOTE) c = "q";
                  if ($urandom_range(0, 11) == 0) c = CH_LF;
                  text_buf.push_back(c);
               end
               text_buf.push_back(CH_QUOTE);
               n = $urandom_range(0, 3);
               repeat (n) text_buf.push_back(rand_text_char());
            end
         endcase
         push_line_end();
      end
   endfunction

   // A text of a few lines, cut short now and then to end inside a line.
   function void build_text();
      int n;
      int keep;
      text_buf.delete();
      n = $urandom_range(1, 5);
      repeat (n) push_line();
      if ($urandom_range(0, 2) == 0) begin
         keep = $urandom_range(1, text_buf.size());
         while (text_buf.size() > keep) void'(text_buf.pop_back());
      end
   endfunction

   // Key register word r built from the current key bytes.
   function logic [63:0] key_word(int r);
      logic [63:0] d;
      d = '0;
      for (int j = 0; j < 8; j++)
         if (8 * r + j < KEY_CHARS) d[8*j +: 8] = key_bytes[8 * r + j];
      return d;
   endfunction

   // Draws a key: empty, short, long, full length, or one that never matches.
   function void pick_key();
      int r;
      int len;
      r = $urandom_range(0, 19);
      key_bytes = '0;
      key_str.delete();
      if (r == 0) begin
         key_bytes = '1;
      end else begin
         len = (r == 1) ? 0 : (r <= 12) ? $urandom_range(1, 6) :
               (r <= 16) ? $urandom_range(7, 30) : KEY_CHARS;
         for (int i = 0; i < len; i++) begin
            key_bytes[i] = rand_alnum();
            key_str.push_back(key_bytes[i]);
         end
         // Bytes past the terminator are junk now and then.
         if (len < KEY_CHARS - 1 && $urandom_range(0, 3) == 0)
            for (int i = len + 1; i < KEY_CHARS; i++)
               key_bytes[i] = 8'($urandom_range(0, 255));
      end
   endfunction

   function logic [63:0] pick_capacity();
      case ($urandom_range(0, 4))
         0: return 64'd1;
         1: return 64'(CAP_RESET);
         2, 3: return 64'($urandom_range(2, 6));
         default: return 64'($urandom_range(1, 255));
      endcase
   endfunction

   // One register write on the configuration channel.
   task automatic write_csr(csr_index_type idx, logic [63:0] d);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= d;
      do @(posedge clock); while (!csr_bus.ready);
      csr_bus.valid <= 1'b0;
      sb.write_reg(idx, d);
      csr_writes++;
   endtask

   task automatic program_key();
      write_csr(CSR_KEY_0_7, key_word(0));
      write_csr(CSR_KEY_8_15, key_word(1));
      write_csr(CSR_KEY_16_23, key_word(2));
      write_csr(CSR_KEY_24_30, key_word(3));
   endtask

   // Waits until every owed word has come, then lets the pipeline settle.
   task automatic wait_idle();
      while (sb.words_outstanding() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Streams the text buffer, end-of-text flag on its last byte.
   task automatic send_text();
      int gap;
      int last;
      last = text_buf.size() - 1;
      gap = draw_wait();
      @(posedge clock);
      repeat (gap) @(posedge clock);
      for (int i = 0; i <= last; i++) begin
         req_bus.valid       <= 1'b1;
         req_bus.text_byte   <= text_buf[i];
         req_bus.end_of_text <= (i == last);
         do @(posedge clock); while (!req_bus.ready);
         sb.note_text_byte(text_buf[i], i == last);
         bytes_sent++;
         gap = draw_wait();
         // Keep valid up across back-to-back words.
         if (i == last || gap > 0) req_bus.valid <= 1'b0;
         if (i != last) repeat (gap) @(posedge clock);
      end
      texts_sent++;
   endtask

   // Result side: accept, check, then stall for a drawn number of cycles.
   initial begin : result_side
      int hold;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            sb.check_word(rsp_bus.result_kind, rsp_bus.value_byte, rsp_bus.key_found,
                          rsp_bus.last_of_run);
            hold = draw_wait();
            if (hold > 0) rsp_bus.ready <= 1'b0;
         end else if (hold > 0) begin
            hold--;
            if (hold == 0) rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Run limit.
   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("timeout after %0d cycles", cycles);
      $display("tb_ini_key_value_extractor: done, errors");
      $finish;
   end

   // Directed texts first, then random texts with changing configuration.
   initial begin : stimulus
      sb = new();
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.text_byte = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready = 1'b1;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_KEY_0_7;
      csr_bus.data = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      key_bytes = '0;
      key_bytes[0] = "a";
      key_bytes[1] = "b";
      key_str = '{8'("a"), 8'("b")};
      program_key();

      // Bare matching name reports '1'.
      text_buf.delete();
      push_str("ab\n");
      send_text();
      // Comment line hides the key; the quoted value on the next line is found.
      text_buf.delete();
      push_str(" ;ab=1\nab:\"x\"");
      send_text();
      // Text ends while a value is still being copied, with a byte above 127.
      text_buf.delete();
      push_str("ab=");
      text_buf.push_back(8'hFF);
      send_text();
      // Key absent.
      text_buf.delete();
      push_str("zz=1");
      send_text();

      wait_idle();
      write_csr(CSR_VALUE_CAP, 64'd1);

      while (bytes_sent < TEXT_BYTES) begin
         no_idle = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 2) == 0) begin
            wait_idle();
            case ($urandom_range(0, 2))
               0: begin
                  pick_key();
                  program_key();
               end
               1: write_csr(CSR_VALUE_CAP, pick_capacity());
               default: begin
                  pick_key();
                  program_key();
                  write_csr(CSR_VALUE_CAP, pick_capacity());
               end
            endcase
         end
         build_text();
         send_text();
      end

      while (sb.words_outstanding() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("covered %0d text bytes in %0d texts, %0d result words checked",
               bytes_sent, texts_sent, sb.checked);
      $display("%0d register writes across keys and value capacities", csr_writes);
      if (sb.words_outstanding() != 0)
         $display("%0d result words never arrived", sb.words_outstanding());
      if (sb.errors == 0 && sb.words_outstanding() == 0)
         $display("tb_ini_key_value_extractor: done, clean");
      else
         $display("tb_ini_key_value_extractor: done, errors");
      $finish;
   end

endmodule
